// File: rtl/mlfq_pkg.sv
// Shared types and constants for the three-level feedback queue scheduler.
// No dependencies.
package mlfq_pkg;

  localparam int NUM_LEVELS_DEF  = 3;
  localparam int LEVEL_DEPTH_DEF = 16;

  localparam int TASK_W  = 8;
  localparam int TIME_W  = 32;
  localparam int QUANT_W = 16;
  localparam int REM_W   = QUANT_W + 1;   // quantum of level 1 is twice the base
  localparam int STEP_W  = $clog2(TIME_W);

  localparam logic [QUANT_W-1:0] BASE_QUANTUM_RST = QUANT_W'(4);

  typedef enum logic [1:0] {
    FN_NEW      = 2'd0,
    FN_PREEMPT  = 2'd1,
    FN_DISPATCH = 2'd2,
    FN_QUERY    = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DIV,
    ST_FIN,
    ST_DONE
  } state_t;

endpackage

// File: rtl/mlfq_task_scheduler.sv
// Three-level feedback queue scheduler: level FIFOs, dispatch and activation query.
// Depends on mlfq_pkg.
//
//   channel   handshake              payload
//   request   req_valid/req_ready    func task_id cpu_free run_time current_time free_time
//   response  rsp_valid/rsp_ready    task_out task_valid activation_time activation_never
//                                    queue_overflow any_pending
//   config    APB psel/penable       paddr pwdata prdata pready (base_quantum at 0x0)
//
// Sequence: ST_IDLE, ST_EXEC, ST_DONE per request; an activation query on a quantum level
// also runs the 32-step remainder loop in ST_DIV through the shared subtractor, then ST_FIN.
// Reset: synchronous; clears heads, counts and running level, loads base_quantum with 4.
// The task store has no reset and no clearing pass.
// Stalls: a new request is taken while a response waits; its own response holds in
// ST_DONE until the response register is free.
module mlfq_task_scheduler
  import mlfq_pkg::*;
#(
  parameter int NUM_LEVELS  = NUM_LEVELS_DEF,
  parameter int LEVEL_DEPTH = LEVEL_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  logic [1:0]        func,
  input  logic [TASK_W-1:0] task_id,
  input  logic              cpu_free,
  input  logic [TIME_W-1:0] run_time,
  input  logic [TIME_W-1:0] current_time,
  input  logic [TIME_W-1:0] free_time,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output logic [TASK_W-1:0] task_out,
  output logic              task_valid,
  output logic [TIME_W-1:0] activation_time,
  output logic              activation_never,
  output logic              queue_overflow,
  output logic              any_pending,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int STORE_DEPTH = NUM_LEVELS * LEVEL_DEPTH;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int SLOT_W      = $clog2(LEVEL_DEPTH);
  localparam int SUM_W       = SLOT_W + 1;
  localparam int CNT_W       = $clog2(LEVEL_DEPTH + 1);
  localparam int LVL_W       = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;

  // configuration
  logic [QUANT_W-1:0] base_quantum;
  logic [QUANT_W-1:0] bq_eff;

  // queue state
  logic [TASK_W-1:0] store [STORE_DEPTH];
  logic [TASK_W-1:0] rd_data;
  logic [SLOT_W-1:0] heads  [NUM_LEVELS];
  logic [CNT_W-1:0]  counts [NUM_LEVELS];
  logic [LVL_W-1:0]  running_level;

  // sequencer and captured request
  state_t             state, state_next;
  func_t              op;
  logic [TASK_W-1:0]  id;
  logic               cpu_idle;
  logic [TIME_W-1:0]  run_t;
  logic [TIME_W-1:0]  now_t;
  logic [TIME_W-1:0]  free_t;

  // remainder unit
  logic [REM_W-1:0]   q;
  logic [REM_W-1:0]   rem;
  logic [TIME_W-1:0]  div_shift;
  logic [STEP_W-1:0]  step;
  logic [REM_W:0]     trial;
  logic               trial_ge;

  // result staging
  logic               res_valid;
  logic [TIME_W-1:0]  res_time;
  logic               res_never;
  logic               res_ovf;

  // datapath decode
  logic [LVL_W:0]     run_inc;
  logic [LVL_W-1:0]   push_lvl;
  logic [LVL_W-1:0]   pop_lvl;
  logic               pop_found;
  logic [LVL_W-1:0]   sel_lvl;
  logic [SLOT_W-1:0]  sel_head;
  logic [CNT_W-1:0]   sel_count;
  logic               sel_full;
  logic [SUM_W-1:0]   tail_sum;
  logic [SLOT_W-1:0]  tail_slot;
  logic [ADDR_W-1:0]  level_base;
  logic               any_wait;
  logic               is_push;
  logic               fcfs_level;

  // sequencer outputs
  logic               exec_cycle;
  logic               mem_wr_en;
  logic               mem_rd_en;
  logic               query_div;
  logic               load_rsp;

  assign bq_eff = (base_quantum == '0) ? QUANT_W'(1) : base_quantum;

  // APB
  assign pready = 1'b1;
  assign prdata = paddr[2] ? '0 : {{(32 - QUANT_W){1'b0}}, base_quantum};

  always_ff @(posedge clk) begin
    if (rst) begin
      base_quantum <= BASE_QUANTUM_RST;
    end else if (psel && penable && pwrite && pready && !paddr[2]) begin
      base_quantum <= pwdata[QUANT_W-1:0];
    end
  end

  // level decode
  always_comb begin
    any_wait  = 1'b0;
    pop_found = 1'b0;
    pop_lvl   = '0;
    for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
      if (counts[i] != '0) begin
        any_wait  = 1'b1;
        pop_found = 1'b1;
        pop_lvl   = LVL_W'(i);
      end
    end
  end

  assign run_inc    = {1'b0, running_level} + (LVL_W + 1)'(1);
  assign push_lvl   = (run_inc >= (LVL_W + 1)'(NUM_LEVELS - 1)) ? LVL_W'(NUM_LEVELS - 1)
                                                               : run_inc[LVL_W-1:0];
  assign is_push    = (op == FN_NEW) || (op == FN_PREEMPT);
  assign sel_lvl    = (op == FN_DISPATCH) ? pop_lvl :
                      (op == FN_PREEMPT)  ? push_lvl : '0;
  assign sel_head   = heads[sel_lvl];
  assign sel_count  = counts[sel_lvl];
  assign sel_full   = (sel_count == CNT_W'(LEVEL_DEPTH));
  assign tail_sum   = SUM_W'(sel_head) + SUM_W'(sel_count);
  assign tail_slot  = (tail_sum >= SUM_W'(LEVEL_DEPTH))
                      ? SLOT_W'(tail_sum - SUM_W'(LEVEL_DEPTH)) : tail_sum[SLOT_W-1:0];
  assign level_base = ADDR_W'(sel_lvl) * ADDR_W'(LEVEL_DEPTH);
  assign fcfs_level = ({1'b0, running_level} >= (LVL_W + 1)'(2));

  // shared subtractor of the remainder loop
  assign trial    = {rem, div_shift[TIME_W-1]};
  assign trial_ge = (trial >= {1'b0, q});

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req_valid) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        state_next = query_div ? ST_DIV : ST_DONE;
      end
      ST_DIV: begin
        if (step == STEP_W'(TIME_W - 1)) state_next = ST_FIN;
      end
      ST_FIN: begin
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!rsp_valid || rsp_ready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    req_ready  = (state == ST_IDLE);
    exec_cycle = (state == ST_EXEC);
    mem_wr_en  = exec_cycle && is_push && !sel_full;
    mem_rd_en  = exec_cycle && (op == FN_DISPATCH) && pop_found;
    query_div  = (op == FN_QUERY) && any_wait && !cpu_idle && !fcfs_level;
    load_rsp   = (state == ST_DONE) && (!rsp_valid || rsp_ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // task store
  always_ff @(posedge clk) begin
    if (mem_wr_en) begin
      store[level_base + ADDR_W'(tail_slot)] <= id;
    end
    if (mem_rd_en) begin
      rd_data <= store[level_base + ADDR_W'(sel_head)];
    end
  end

  // queue control state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_LEVELS; i++) begin
        heads[i]  <= '0;
        counts[i] <= '0;
      end
      running_level <= '0;
    end else if (mem_wr_en) begin
      counts[sel_lvl] <= sel_count + CNT_W'(1);
    end else if (mem_rd_en) begin
      counts[sel_lvl] <= sel_count - CNT_W'(1);
      heads[sel_lvl]  <= (sel_head == SLOT_W'(LEVEL_DEPTH - 1)) ? '0
                                                                : sel_head + SLOT_W'(1);
      running_level   <= sel_lvl;
    end
  end

  // request capture, remainder loop and result staging
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (req_valid) begin
          op       <= func_t'(func);
          id       <= task_id;
          cpu_idle <= cpu_free;
          run_t    <= run_time;
          now_t    <= current_time;
          free_t   <= free_time;
        end
      end
      ST_EXEC: begin
        res_valid <= mem_rd_en;
        res_ovf   <= is_push && sel_full;
        res_never <= (op == FN_QUERY) && !any_wait;
        if (op == FN_QUERY && any_wait && cpu_idle) begin
          res_time <= now_t;
        end else if (op == FN_QUERY && any_wait && fcfs_level) begin
          res_time <= free_t;
        end else begin
          res_time <= '0;
        end
        q         <= (running_level == '0) ? {1'b0, bq_eff} : {bq_eff, 1'b0};
        rem       <= '0;
        div_shift <= run_t;
        step      <= '0;
      end
      ST_DIV: begin
        rem       <= trial_ge ? REM_W'(trial - {1'b0, q}) : trial[REM_W-1:0];
        div_shift <= {div_shift[TIME_W-2:0], 1'b0};
        step      <= step + STEP_W'(1);
      end
      ST_FIN: begin
        res_time <= (rem == '0 && run_t != '0) ? now_t
                                               : now_t + TIME_W'(q - rem);
      end
      default: ;
    endcase
  end

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (load_rsp) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_rsp) begin
      task_out         <= res_valid ? rd_data : '0;
      task_valid       <= res_valid;
      activation_time  <= res_time;
      activation_never <= res_never;
      queue_overflow   <= res_ovf;
      any_pending      <= any_wait;
    end
  end

`ifndef NO_ASSERTIONS
  for (genvar g = 0; g < NUM_LEVELS; g++) begin : g_cnt_chk
    a_count_bound: assert property (@(posedge clk) disable iff (rst)
      counts[g] <= CNT_W'(LEVEL_DEPTH))
      else $error("level count above depth");
  end

  a_never_empty: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && activation_never |-> !any_pending)
    else $error("no activation reported while tasks wait");

  a_dispatch_only: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && task_valid |-> !activation_never && !queue_overflow && activation_time == '0)
    else $error("dispatch response carries query or overflow fields");

  a_div_exit: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV |=> state == ST_DIV || state == ST_FIN)
    else $error("remainder loop left early");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("second request taken while busy");
`endif

endmodule

// File: bench/mlfq_sched_checker.sv
`timescale 1ns / 100ps
// Response checker for the feedback queue scheduler: keeps its own copy of the level FIFOs,
// predicts each response from the accepted requests and the APB quantum writes.
// Depends on mlfq_pkg.
module mlfq_sched_checker
  import mlfq_pkg::*;
#(
  parameter logic [2:0] QUANTUM_ADDR = 3'd0
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  input  logic              req_ready,
  input  logic [1:0]        func,
  input  logic [TASK_W-1:0] task_id,
  input  logic              cpu_free,
  input  logic [TIME_W-1:0] run_time,
  input  logic [TIME_W-1:0] current_time,
  input  logic [TIME_W-1:0] free_time,
  input  logic              rsp_valid,
  input  logic              rsp_ready,
  input  logic [TASK_W-1:0] task_out,
  input  logic              task_valid,
  input  logic [TIME_W-1:0] activation_time,
  input  logic              activation_never,
  input  logic              queue_overflow,
  input  logic              any_pending,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  input  logic              pready,
  output int                fails,
  output int                pending
);

  localparam int LEVELS = NUM_LEVELS_DEF;
  localparam int DEPTH  = LEVEL_DEPTH_DEF;
  localparam int LAST   = LEVELS - 1;

  typedef struct packed {
    logic [TASK_W-1:0] task_out;
    logic              task_valid;
    logic [TIME_W-1:0] activation_time;
    logic              activation_never;
    logic              queue_overflow;
    logic              any_pending;
  } sched_rsp_t;

  logic [TASK_W-1:0]  slots [LEVELS][DEPTH];
  int unsigned        head  [LEVELS];
  int unsigned        count [LEVELS];
  int unsigned        run_lvl;
  logic [QUANT_W-1:0] quantum;
  sched_rsp_t         due_rsps [$];
  int                 fail_cnt = 0;
  int                 due_cnt = 0;

  assign fails   = fail_cnt;
  assign pending = due_cnt;

  function automatic bit any_waiting();
    int i;
    for (i = 0; i < LEVELS; i++)
      if (count[i] != 0) return 1'b1;
    return 1'b0;
  endfunction

  // returns 1 when the level is full and the task is dropped
  function automatic bit enqueue_task(int unsigned lvl, logic [TASK_W-1:0] id);
    int unsigned slot;
    if (lvl > LAST) lvl = LAST;
    if (count[lvl] >= DEPTH) return 1'b1;
    slot = (head[lvl] + count[lvl]) % DEPTH;
    slots[lvl][slot] = id;
    count[lvl]++;
    return 1'b0;
  endfunction

  function automatic sched_rsp_t schedule_step(func_t fn, logic [TASK_W-1:0] id,
                                               logic idle_cpu, logic [TIME_W-1:0] ran,
                                               logic [TIME_W-1:0] now,
                                               logic [TIME_W-1:0] free);
    sched_rsp_t        r;
    logic [TIME_W-1:0] q;
    logic [TIME_W-1:0] rem;
    int                i;
    r = '0;
    case (fn)
      FN_NEW: r.queue_overflow = enqueue_task(0, id);
      FN_PREEMPT: r.queue_overflow = enqueue_task(run_lvl + 1, id);
      FN_DISPATCH: begin
        for (i = 0; i < LEVELS; i++) begin
          if (!r.task_valid && count[i] != 0) begin
            r.task_out   = slots[i][head[i]];
            r.task_valid = 1'b1;
            head[i]      = (head[i] + 1) % DEPTH;
            count[i]--;
            run_lvl      = i;
          end
        end
      end
      default: begin
        if (!any_waiting()) begin
          r.activation_never = 1'b1;
        end else if (idle_cpu) begin
          r.activation_time = now;
        end else if (run_lvl >= 2) begin
          r.activation_time = free;
        end else begin
          q = (quantum == '0) ? TIME_W'(1) : TIME_W'(quantum);
          if (run_lvl != 0) q = q << 1;
          rem = ran % q;
          r.activation_time = (rem == '0 && ran != '0) ? now : now + q - rem;
        end
      end
    endcase
    r.any_pending = any_waiting();
    return r;
  endfunction

  task automatic check_field(string name, logic [TIME_W-1:0] want, logic [TIME_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fail_cnt++;
    end
  endtask

  always @(posedge clk) begin : watch
    sched_rsp_t want;
    int         i;
    if (rst) begin
      for (i = 0; i < LEVELS; i++) begin
        head[i]  = 0;
        count[i] = 0;
      end
      run_lvl = 0;
      quantum = BASE_QUANTUM_RST;
      due_rsps.delete();
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (due_rsps.size() == 0) begin
          $error("response with no request outstanding");
          fail_cnt++;
        end else begin
          want = due_rsps.pop_front();
          check_field("task_out", TIME_W'(want.task_out), TIME_W'(task_out));
          check_field("task_valid", TIME_W'(want.task_valid), TIME_W'(task_valid));
          check_field("activation_time", want.activation_time, activation_time);
          check_field("activation_never", TIME_W'(want.activation_never),
                      TIME_W'(activation_never));
          check_field("queue_overflow", TIME_W'(want.queue_overflow),
                      TIME_W'(queue_overflow));
          check_field("any_pending", TIME_W'(want.any_pending), TIME_W'(any_pending));
        end
      end
      if (req_valid && req_ready)
        due_rsps.push_back(schedule_step(func_t'(func), task_id, cpu_free, run_time,
                                         current_time, free_time));
      if (psel && penable && pwrite && pready && paddr == QUANTUM_ADDR)
        quantum = pwdata[QUANT_W-1:0];
    end
    due_cnt = due_rsps.size();
  end

endmodule

// File: bench/tb_mlfq_task_scheduler.sv
`timescale 1ns / 100ps
// Testbench top for mlfq_task_scheduler: directed and random scheduler requests under
// varying sender idling and receiver stalls, quantum set over APB. Depends on mlfq_pkg
// and mlfq_sched_checker.
module tb_mlfq_task_scheduler;
  import mlfq_pkg::*;

  localparam logic [2:0] QUANTUM_ADDR    = 3'd0;
  localparam int         WATCHDOG_LIMIT  = 2000;
  localparam int         ITEMS_PER_PHASE = 210;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              req_valid = 1'b0;
  logic              req_ready;
  logic [1:0]        func = FN_NEW;
  logic [TASK_W-1:0] task_id = '0;
  logic              cpu_free = 1'b0;
  logic [TIME_W-1:0] run_time = '0;
  logic [TIME_W-1:0] current_time = '0;
  logic [TIME_W-1:0] free_time = '0;
  logic              rsp_valid;
  logic              rsp_ready = 1'b0;
  logic [TASK_W-1:0] task_out;
  logic              task_valid;
  logic [TIME_W-1:0] activation_time;
  logic              activation_never;
  logic              queue_overflow;
  logic              any_pending;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [2:0]        paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  int                fails;
  int                pending;
  int                send_idle_pct = 0;
  int                stall_pct = 0;
  int                stuck_cycles = 0;
  int                sent = 0;
  logic [QUANT_W-1:0] cur_quantum = BASE_QUANTUM_RST;

  mlfq_task_scheduler u_top (.*);

  mlfq_sched_checker #(.QUANTUM_ADDR(QUANTUM_ADDR)) u_check (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(negedge clk)
    rsp_ready = (stall_pct == 0) || ($urandom_range(99) >= stall_pct);

  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_mlfq_task_scheduler failed");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // called at a falling edge; leaves valid high so back-to-back requests need no gap
  task automatic send_req(func_t fn, logic [TASK_W-1:0] id, logic idle_cpu,
                          logic [TIME_W-1:0] ran, logic [TIME_W-1:0] now,
                          logic [TIME_W-1:0] free);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      req_valid = 1'b0;
      @(negedge clk);
    end
    req_valid    = 1'b1;
    func         = fn;
    task_id      = id;
    cpu_free     = idle_cpu;
    run_time     = ran;
    current_time = now;
    free_time    = free;
    do @(posedge clk); while (!req_ready);
    @(negedge clk);
    sent++;
  endtask

  task automatic wait_drained();
    req_valid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic send_random(func_t fn, int free_pct);
    logic [TIME_W-1:0] q;
    logic [TIME_W-1:0] ran;
    logic [TIME_W-1:0] now;
    q = (cur_quantum == '0) ? TIME_W'(1) : TIME_W'(cur_quantum);
    if ($urandom_range(1)) q = q << 1;
    case ($urandom_range(4))
      0: ran = '0;
      1: ran = $urandom_range(3 * q);
      2: ran = q * $urandom_range(1000, 1);
      3: ran = ~TIME_W'($urandom_range(50));
      default: ran = $urandom;
    endcase
    now = ($urandom_range(3) == 0) ? ~TIME_W'($urandom_range(200000)) : TIME_W'($urandom);
    send_req(fn, TASK_W'($urandom), $urandom_range(99) < free_pct, ran, now, $urandom);
  endtask

  initial begin
    logic [QUANT_W-1:0] phase_quantum [4];
    int                 phase_idle    [4];
    int                 phase_stall   [4];
    int                 p;
    int                 fill_pct;
    int                 next_shift;
    int                 drain_at;
    bit                 drained;
    func_t              fn;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: reset quantum of 4, walk one task pair down all three levels
    send_req(FN_QUERY,    8'h5A, 1'b0, 32'd5,  32'd100, 32'd0);
    send_req(FN_DISPATCH, 8'hA5, 1'b1, '1,     '1,      '1);
    send_req(FN_NEW,      8'h00, 1'b0, '0,     '0,      '0);
    send_req(FN_QUERY,    8'h00, 1'b1, 32'd3,  '1,      32'd9);
    send_req(FN_QUERY,    8'h00, 1'b0, 32'd0,  32'd1000, 32'd9);
    send_req(FN_QUERY,    8'h00, 1'b0, 32'd8,  32'd1000, 32'd9);
    send_req(FN_QUERY,    8'h00, 1'b0, 32'd7,  32'hFFFF_FFFE, 32'd9);
    send_req(FN_NEW,      8'hFF, 1'b1, '1,     '1,      '1);
    send_req(FN_DISPATCH, 8'h00, 1'b0, '0,     '0,      '0);
    send_req(FN_PREEMPT,  8'h00, 1'b0, '0,     '0,      '0);
    send_req(FN_DISPATCH, 8'h00, 1'b0, '0,     '0,      '0);
    send_req(FN_PREEMPT,  8'hFF, 1'b0, '0,     '0,      '0);
    send_req(FN_DISPATCH, 8'h00, 1'b0, '0,     '0,      '0);
    send_req(FN_QUERY,    8'h00, 1'b0, 32'd16, 32'd77,  32'd9);
    send_req(FN_QUERY,    8'h00, 1'b0, '1,     '1,      32'd9);
    send_req(FN_PREEMPT,  8'h00, 1'b0, '0,     '0,      '0);
    send_req(FN_DISPATCH, 8'h00, 1'b0, '0,     '0,      '0);
    send_req(FN_PREEMPT,  8'hFF, 1'b0, '0,     '0,      '0);
    send_req(FN_DISPATCH, 8'h00, 1'b0, '0,     '0,      '0);
    send_req(FN_QUERY,    8'h00, 1'b0, 32'd5,  32'd77,  '1);
    send_req(FN_PREEMPT,  8'h00, 1'b0, '0,     '0,      '0);
    send_req(FN_QUERY,    8'h00, 1'b1, '1,     32'd0,   32'd1);
    send_req(FN_DISPATCH, 8'h00, 1'b0, '0,     '0,      '0);
    send_req(FN_DISPATCH, 8'h00, 1'b0, '0,     '0,      '0);
    send_req(FN_QUERY,    8'h00, 1'b0, 32'd9,  32'd77,  32'd1);

    phase_quantum[0] = '0;
    phase_quantum[1] = '1;
    phase_quantum[2] = QUANT_W'(1);
    phase_quantum[3] = QUANT_W'($urandom_range(200, 2));
    phase_idle[0]  = 0;  phase_idle[1]  = 78; phase_idle[2]  = 0;  phase_idle[3]  = 9;
    phase_stall[0] = 0;  phase_stall[1] = 0;  phase_stall[2] = 78; phase_stall[3] = 9;

    for (p = 0; p < 4; p++) begin
      wait_drained();
      // quantum write while the scheduler is idle; upper data bits are ignored
      cur_quantum = phase_quantum[p];
      psel    = 1'b1;
      penable = 1'b0;
      pwrite  = 1'b1;
      paddr   = QUANTUM_ADDR;
      pwdata  = {16'($urandom), phase_quantum[p]};
      @(negedge clk);
      penable = 1'b1;
      do @(posedge clk); while (!pready);
      @(negedge clk);
      psel    = 1'b0;
      penable = 1'b0;
      pwrite  = 1'b0;

      send_idle_pct = phase_idle[p];
      stall_pct     = phase_stall[p];
      sent          = 0;
      fill_pct      = 50;
      next_shift    = 0;
      drained       = 1'b0;
      drain_at      = $urandom_range(ITEMS_PER_PHASE - 20, 20);
      while (sent < ITEMS_PER_PHASE) begin
        if (sent >= next_shift) begin
          // switch at random among filling, balanced and draining mixes so levels empty and overflow
          case ($urandom_range(2))
            0: fill_pct = 15;
            1: fill_pct = 50;
            default: fill_pct = 85;
          endcase
          next_shift = sent + $urandom_range(40, 15);
        end
        if (!drained && sent >= drain_at) begin
          wait_drained();
          drained = 1'b1;
        end
        if ($urandom_range(99) < 40) begin
          // scheduler round: dispatch, busy query, preempt back
          send_random(FN_DISPATCH, 30);
          send_random(FN_QUERY, 0);
          send_random(FN_PREEMPT, 30);
        end else begin
          if ($urandom_range(99) < fill_pct)
            fn = $urandom_range(1) ? FN_NEW : FN_PREEMPT;
          else
            fn = ($urandom_range(99) < 45) ? FN_DISPATCH : FN_QUERY;
          send_random(fn, 30);
        end
      end
    end

    wait_drained();
    repeat (40) @(negedge clk);
    if (fails == 0)
      $display("tb_mlfq_task_scheduler passed");
    else
      $display("tb_mlfq_task_scheduler failed");
    $finish;
  end

endmodule

// File: files.f
rtl/mlfq_pkg.sv
rtl/mlfq_task_scheduler.sv
bench/mlfq_sched_checker.sv
bench/tb_mlfq_task_scheduler.sv
